// File: rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, codes and helpers for the checksummed packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

   // Receive buffer size; the payload is dropped at BUFFER_BYTES-1 bytes.
   localparam int BUFFER_BYTES = 2048;
   localparam int CNT_W        = $clog2(BUFFER_BYTES);
   localparam int LEN_W        = 11;
   localparam int SAT_W        = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   localparam int MAX_RESULTS = 4;
   localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_TX      = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   localparam logic [1:0] ST_GOOD     = 2'd0;
   localparam logic [1:0] ST_BAD_SUM  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_RESTART  = 2'd3;

   localparam logic [1:0] START_NONE = 2'd0;
   localparam logic [1:0] START_SEQ  = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_HEX1 = 2'd2,
      PH_HEX2 = 2'd3
   } phase_type;

   // data fields packed lowest first: byte_value at bit 0
   typedef struct packed {
      logic [1:0]       kind;
      logic [LEN_W-1:0] payload_length;
      logic [1:0]       payload_start;
      logic [1:0]       status;
      logic [LEN_W-1:0] byte_index;
      logic [7:0]       byte_value;
   } rsp_item_type;

   typedef struct packed {
      logic                              load;
      logic [RES_CNT_W-1:0]              cnt;
      rsp_item_type [MAX_RESULTS-1:0]    item;
   } grp_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] t;
      logic [4:0] r;
      t = 8'h00;
      r = 5'h00;
      if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
         r = {1'b1, t[3:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
         r = {1'b1, t[3:0]};
      end
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] v);
      logic [SAT_W-1:0] w;
      w = SAT_W'(v);
      return (w > SAT_W'(LEN_MAX)) ? LEN_MAX : w[LEN_W-1:0];
   endfunction

endpackage

// File: rtl/checksummed_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// checksummed_packet_deframer_top
// Receives "$payload#hh" packets a byte per beat; emits payload, ack and verdict.
// ----------------------------------------------------------------------------
// Path: a byte taken passes the input register, then the result group register,
//    before its first result beat appears.
// Throughput: one byte per cycle when rsp_tready is high; a byte causing more than one result
//    holds the input until the result group register has drained them one beat at a time.
// Reset: synchronous, active high; idle, waiting for '$', no results pending.
// ----------------------------------------------------------------------------
module checksummed_packet_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] byte_value, [18:8] byte_index,
                                    // [20:19] status, [22:21] payload_start,
                                    // [33:23] payload_length, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import cpd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff, in_byte_in;
   logic         grp_ready;
   grp_type      grp;
   rsp_item_type item;

   assign req_tready = !in_valid_ff || grp_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (grp_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   cpd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_byte   (in_byte_ff),
      .grp_ready (grp_ready),
      .grp       (grp)
   );

   cpd_out_seq u_out_seq (
      .clock     (clock),
      .reset     (reset),
      .grp_in    (grp),
      .grp_ready (grp_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (item),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = item.kind;
   assign rsp_tdata = {6'b0, item.payload_length, item.payload_start, item.status,
                       item.byte_index, item.byte_value};

endmodule

// File: rtl/cpd_parser.sv
// ----------------------------------------------------------------------------
// cpd_parser
// Framing state machine: turns one received byte into a group of zero or more results.
// ----------------------------------------------------------------------------
module cpd_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [7:0]       in_byte,
   input  logic             grp_ready,
   output cpd_pkg::grp_type grp
);
   import cpd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [7:0]       running_sum_ff, running_sum_in;
   logic [CNT_W-1:0] payload_count_ff, payload_count_in;
   logic [3:0]       high_nibble_ff, high_nibble_in;
   logic             nibble_bad_ff, nibble_bad_in;
   logic [7:0]       seq_first_ff, seq_first_in;
   logic [7:0]       seq_second_ff, seq_second_in;
   logic             colon_at_two_ff, colon_at_two_in;

   logic             step;
   logic [CNT_W-1:0] count_inc;
   logic             at_limit;
   logic [4:0]       hex;
   logic             sum_good;
   logic             has_seq;

   assign step      = in_valid && grp_ready;
   assign count_inc = payload_count_ff + CNT_W'(1);
   assign at_limit  = count_inc >= CNT_W'(BUFFER_BYTES - 1);
   assign hex       = hex_digit(in_byte);
   assign sum_good  = !nibble_bad_ff && hex[4] && ({high_nibble_ff, hex[3:0]} == running_sum_ff);
   assign has_seq   = (payload_count_ff >= CNT_W'(3)) && colon_at_two_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            PH_IDLE: if (in_byte == CH_DOLLAR) phase_in = PH_DATA;
            PH_DATA: begin
               if (in_byte == CH_DOLLAR)    phase_in = PH_DATA;
               else if (in_byte == CH_HASH) phase_in = PH_HEX1;
               else if (at_limit)           phase_in = PH_IDLE;
            end
            PH_HEX1: phase_in = PH_HEX2;
            PH_HEX2: phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // datapath updates and result group
   always_comb begin
      running_sum_in   = running_sum_ff;
      payload_count_in = payload_count_ff;
      high_nibble_in   = high_nibble_ff;
      nibble_bad_in    = nibble_bad_ff;
      seq_first_in     = seq_first_ff;
      seq_second_in    = seq_second_ff;
      colon_at_two_in  = colon_at_two_ff;
      grp              = '0;

      if (step) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (in_byte == CH_DOLLAR) begin
                  running_sum_in   = '0;
                  payload_count_in = '0;
                  high_nibble_in   = '0;
                  nibble_bad_in    = 1'b0;
                  seq_first_in     = '0;
                  seq_second_in    = '0;
                  colon_at_two_in  = 1'b0;
               end
            end
            PH_DATA: begin
               if (in_byte == CH_DOLLAR) begin
                  grp.load                   = 1'b1;
                  grp.cnt                    = RES_CNT_W'(1);
                  grp.item[0].kind           = KIND_VERDICT;
                  grp.item[0].status         = ST_RESTART;
                  grp.item[0].payload_length = sat_len(payload_count_ff);
                  running_sum_in   = '0;
                  payload_count_in = '0;
                  high_nibble_in   = '0;
                  nibble_bad_in    = 1'b0;
                  seq_first_in     = '0;
                  seq_second_in    = '0;
                  colon_at_two_in  = 1'b0;
               end else if (in_byte != CH_HASH) begin
                  grp.load               = 1'b1;
                  grp.cnt                = RES_CNT_W'(1);
                  grp.item[0].kind       = KIND_PAYLOAD;
                  grp.item[0].byte_value = in_byte;
                  grp.item[0].byte_index = sat_len(payload_count_ff);
                  if (payload_count_ff == CNT_W'(0)) seq_first_in = in_byte;
                  if (payload_count_ff == CNT_W'(1)) seq_second_in = in_byte;
                  if (payload_count_ff == CNT_W'(2)) colon_at_two_in = (in_byte == CH_COLON);
                  running_sum_in   = running_sum_ff + in_byte;
                  payload_count_in = count_inc;
                  if (at_limit) begin
                     grp.cnt                    = RES_CNT_W'(2);
                     grp.item[1].kind           = KIND_VERDICT;
                     grp.item[1].status         = ST_OVERFLOW;
                     grp.item[1].payload_length = sat_len(count_inc);
                  end
               end
            end
            PH_HEX1: begin
               if (!hex[4]) begin
                  nibble_bad_in  = 1'b1;
                  high_nibble_in = '0;
               end else begin
                  high_nibble_in = hex[3:0];
               end
            end
            PH_HEX2: begin
               grp.load        = 1'b1;
               grp.item[0].kind = KIND_TX;
               if (!sum_good) begin
                  grp.cnt                    = RES_CNT_W'(2);
                  grp.item[0].byte_value     = CH_MINUS;
                  grp.item[1].kind           = KIND_VERDICT;
                  grp.item[1].status         = ST_BAD_SUM;
                  grp.item[1].payload_length = sat_len(payload_count_ff);
               end else if (has_seq) begin
                  grp.cnt                    = RES_CNT_W'(4);
                  grp.item[0].byte_value     = CH_PLUS;
                  grp.item[1].kind           = KIND_TX;
                  grp.item[1].byte_value     = seq_first_ff;
                  grp.item[2].kind           = KIND_TX;
                  grp.item[2].byte_value     = seq_second_ff;
                  grp.item[3].kind           = KIND_VERDICT;
                  grp.item[3].status         = ST_GOOD;
                  grp.item[3].payload_start  = START_SEQ;
                  grp.item[3].payload_length = sat_len(payload_count_ff);
               end else begin
                  grp.cnt                    = RES_CNT_W'(2);
                  grp.item[0].byte_value     = CH_PLUS;
                  grp.item[1].kind           = KIND_VERDICT;
                  grp.item[1].status         = ST_GOOD;
                  grp.item[1].payload_start  = START_NONE;
                  grp.item[1].payload_length = sat_len(payload_count_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         running_sum_ff   <= '0;
         payload_count_ff <= '0;
         high_nibble_ff   <= '0;
         nibble_bad_ff    <= 1'b0;
         seq_first_ff     <= '0;
         seq_second_ff    <= '0;
         colon_at_two_ff  <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         running_sum_ff   <= running_sum_in;
         payload_count_ff <= payload_count_in;
         high_nibble_ff   <= high_nibble_in;
         nibble_bad_ff    <= nibble_bad_in;
         seq_first_ff     <= seq_first_in;
         seq_second_ff    <= seq_second_in;
         colon_at_two_ff  <= colon_at_two_in;
      end
   end

   // the checksum byte always produces an answer and a verdict
   a_hex2_answers: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_HEX2) |-> (grp.load && grp.cnt >= RES_CNT_W'(2)))
      else $error("checksum byte produced no answer");

   // payload never sits at or above the drop limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (payload_count_ff < CNT_W'(BUFFER_BYTES - 1)))
      else $error("payload count past drop limit");

endmodule

// File: rtl/cpd_out_seq.sv
// ----------------------------------------------------------------------------
// cpd_out_seq
// Result group register; hands out its results one beat at a time.
// ----------------------------------------------------------------------------
module cpd_out_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  cpd_pkg::grp_type      grp_in,
   output logic                  grp_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cpd_pkg::rsp_item_type out_item,
   output logic                  out_last
);
   import cpd_pkg::*;

   logic                                grp_valid_ff, grp_valid_in;
   logic [RES_IDX_W-1:0]                idx_ff, idx_in;
   logic [RES_CNT_W-1:0]                cnt_ff, cnt_in;
   rsp_item_type [MAX_RESULTS-1:0]      item_ff, item_in;

   assign out_valid = grp_valid_ff;
   assign out_item  = item_ff[idx_ff];
   assign out_last  = RES_CNT_W'(idx_ff) == (cnt_ff - RES_CNT_W'(1));
   // a new group may load while the last beat of the current one leaves
   assign grp_ready = !grp_valid_ff || (out_ready && out_last);

   always_comb begin
      grp_valid_in = grp_valid_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      if (grp_in.load) begin
         grp_valid_in = 1'b1;
         idx_in       = '0;
         cnt_in       = grp_in.cnt;
         item_in      = grp_in.item;
      end else if (grp_valid_ff && out_ready) begin
         if (out_last) grp_valid_in = 1'b0;
         else          idx_in       = idx_ff + RES_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (RES_CNT_W'(idx_ff) < cnt_ff))
      else $error("result index beyond group size");

   a_load_when_ready: assert property (@(posedge clock) disable iff (reset)
      grp_in.load |-> grp_ready)
      else $error("group loaded over pending results");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      grp_in.load |-> (grp_in.cnt != '0 && grp_in.cnt <= RES_CNT_W'(MAX_RESULTS)))
      else $error("bad result count");

endmodule
